[rtl/core/tmhd_pkg.sv]
// Timer heap dispatcher package: command and status codes, heap key type,
// ordering function and default sizes. No dependencies.
`timescale 1ns / 1ps
package tmhd_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIMER_SLOTS_DEF = 16;
	localparam int ADDR_W          = 3;

	localparam logic [2:0] CMD_SUBMIT   = 3'd0;
	localparam logic [2:0] CMD_SCHEDULE = 3'd1;
	localparam logic [2:0] CMD_CANCEL   = 3'd2;
	localparam logic [2:0] CMD_DISPATCH = 3'd3;
	localparam logic [2:0] CMD_FLUSH    = 3'd4;

	localparam logic [2:0] RS_ACCEPTED = 3'd0;
	localparam logic [2:0] RS_FULL     = 3'd1;
	localparam logic [2:0] RS_STOPPED  = 3'd2;
	localparam logic [2:0] RS_INVALID  = 3'd3;
	localparam logic [2:0] RS_NOTFOUND = 3'd4;
	localparam logic [2:0] RS_NOTHING  = 3'd5;

	localparam logic REG_ACCEPTING = 1'b0;

	typedef struct packed {
		logic [63:0] deadline;
		logic [31:0] stamp;
	} key_t;

	function automatic logic earlier(key_t a, key_t b);
		if (a.deadline != b.deadline) begin
			return a.deadline < b.deadline;
		end
		return a.stamp < b.stamp;
	endfunction

endpackage

[rtl/core/tmhd_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on nothing.
`timescale 1ns / 1ps
interface tmhd_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] task_id;
	logic [63:0] deadline;
	logic [3:0]  timer_slot;
	logic [15:0] timer_generation;
	logic [63:0] now_tick;

	modport source (output valid, cmd, task_id, deadline, timer_slot, timer_generation,
		now_tick, input ready);
	modport sink (input valid, cmd, task_id, deadline, timer_slot, timer_generation,
		now_tick, output ready);
endinterface

interface tmhd_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] task_out;
	logic [3:0]  slot_out;
	logic [15:0] generation_out;
	logic        from_timer;
	logic [4:0]  flushed_count;

	modport source (output valid, status, task_out, slot_out, generation_out, from_timer,
		flushed_count, input ready);
	modport sink (input valid, status, task_out, slot_out, generation_out, from_timer,
		flushed_count, output ready);
endinterface

[rtl/core/tmhd_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
module tmhd_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/tmhd_cfg.sv]
// APB register block holding the accepting control bit.
// Depends on tmhd_pkg.
`timescale 1ns / 1ps
module tmhd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmhd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic                        accepting
);

	logic accepting_q;

	assign pready    = 1'b1;
	assign accepting = accepting_q;
	assign prdata    = (paddr[2] == tmhd_pkg::REG_ACCEPTING) ? {31'd0, accepting_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepting_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr[2] == tmhd_pkg::REG_ACCEPTING) begin
			accepting_q <= pwdata[0];
		end
	end

endmodule

[rtl/core/timer_heap_task_dispatcher.sv]
// Timer heap task dispatcher top level: command sequencer over RAM-held heap,
// slot tables, free-slot stack and task ring. Depends on tmhd_pkg, tmhd_if,
// tmhd_ram and tmhd_cfg.
//
// Usage: commands arrive on cmd_ch (valid/ready), one result item per command
// leaves on res_ch. The accepting bit must be written over the APB port only
// while idle; the block itself does not enforce this. A command is taken only
// when the sequencer is idle; its result is loaded into an output register,
// so a stalled receiver holds the result there. The next command can still be
// taken, but its result is held back until the earlier result has been
// accepted. A timer removal (dispatch of an expired timer, cancel) walks the
// heap level by level, as does schedule. Flush repeats the removal once per
// live timer. The time taken is set by the single registered read port of the
// heap RAMs, one entry per cycle. Reset empties the heap and ring and refills
// the free-slot stack with every slot at once through counts and valid bits;
// no clearing pass is needed.
`timescale 1ns / 1ps
module timer_heap_task_dispatcher #(
	parameter int QUEUE_DEPTH = tmhd_pkg::QUEUE_DEPTH_DEF,
	parameter int TIMER_SLOTS = tmhd_pkg::TIMER_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmhd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	tmhd_cmd_if.sink                    cmd_ch,
	tmhd_res_if.source                  res_ch
);

	localparam int SW  = $clog2(TIMER_SLOTS);
	localparam int CW  = $clog2(TIMER_SLOTS + 1);
	localparam int QW  = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_SCHA = 5'd1;
	localparam logic [4:0] S_SCHB = 5'd2;
	localparam logic [4:0] S_CANA = 5'd3;
	localparam logic [4:0] S_DSPA = 5'd4;
	localparam logic [4:0] S_TK0  = 5'd5;
	localparam logic [4:0] S_TK1  = 5'd6;
	localparam logic [4:0] S_TK2  = 5'd7;
	localparam logic [4:0] S_UP   = 5'd8;
	localparam logic [4:0] S_UPB  = 5'd9;
	localparam logic [4:0] S_DN   = 5'd10;
	localparam logic [4:0] S_DNB  = 5'd11;
	localparam logic [4:0] S_DNC  = 5'd12;
	localparam logic [4:0] S_END  = 5'd13;
	localparam logic [4:0] S_DONE = 5'd14;

	logic accepting;

	tmhd_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.accepting(accepting)
	);

	// control state
	logic [4:0]             st_q;
	logic [CW-1:0]          heap_cnt_q;
	logic [CW-1:0]          free_cnt_q;
	logic [QW-1:0]          fifo_head_q;
	logic [QCW-1:0]         fifo_cnt_q;
	logic [31:0]            stamp_q;
	logic [TIMER_SLOTS-1:0] live_q;
	logic [TIMER_SLOTS-1:0] genv_q;
	logic [TIMER_SLOTS-1:0] freev_q;
	logic                   ovalid_q;

	// working registers
	logic [2:0]             cmd_q;
	logic [31:0]            task_q;
	logic [63:0]            dl_q;
	logic [15:0]            tgen_q;
	logic [63:0]            now_q;
	logic [SW-1:0]          s_q;
	logic [SW-1:0]          tp_q;
	logic [SW-1:0]          hole_q;
	logic                   first_q;
	tmhd_pkg::key_t         xk_q;
	logic [SW-1:0]          xs_q;
	tmhd_pkg::key_t         lk_q;
	logic [SW-1:0]          ls_q;
	logic [CW-1:0]          fl_n_q;

	logic [2:0]  r_status_q;
	logic [31:0] r_task_q;
	logic [3:0]  r_slot_q;
	logic [15:0] r_gen_q;
	logic        r_ft_q;
	logic [4:0]  r_fl_q;

	logic [2:0]  o_status_q;
	logic [31:0] o_task_q;
	logic [3:0]  o_slot_q;
	logic [15:0] o_gen_q;
	logic        o_ft_q;
	logic [4:0]  o_fl_q;

	// RAM ports
	logic           hk_we, hs_we, pos_we, tsk_we, gen_we, fr_we, ff_we;
	logic [SW-1:0]  hk_wa, hk_ra, pos_wa, pos_ra, tsk_wa, tsk_ra, gen_wa, gen_ra;
	logic [SW-1:0]  fr_wa, fr_ra;
	logic [QW-1:0]  ff_wa;
	tmhd_pkg::key_t hk_wd, hk_rd;
	logic [SW-1:0]  hs_wd, hs_rd, pos_wd, pos_rd, fr_wd, fr_rd;
	logic [31:0]    tsk_wd, tsk_rd, ff_wd, ff_rd;
	logic [15:0]    gen_wd, gen_rd;

	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH($bits(tmhd_pkg::key_t))) u_heap_key (
		.clk(clk), .we(hk_we), .waddr(hk_wa), .wdata(hk_wd), .raddr(hk_ra), .rdata(hk_rd));
	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(SW)) u_heap_slot (
		.clk(clk), .we(hs_we), .waddr(hk_wa), .wdata(hs_wd), .raddr(hk_ra), .rdata(hs_rd));
	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(SW)) u_slot_pos (
		.clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra),
		.rdata(pos_rd));
	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(32)) u_slot_task (
		.clk(clk), .we(tsk_we), .waddr(tsk_wa), .wdata(tsk_wd), .raddr(tsk_ra),
		.rdata(tsk_rd));
	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(16)) u_slot_gen (
		.clk(clk), .we(gen_we), .waddr(gen_wa), .wdata(gen_wd), .raddr(gen_ra),
		.rdata(gen_rd));
	tmhd_ram #(.DEPTH(TIMER_SLOTS), .WIDTH(SW)) u_free_stack (
		.clk(clk), .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));
	tmhd_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(32)) u_fifo (
		.clk(clk), .we(ff_we), .waddr(ff_wa), .wdata(ff_wd), .raddr(fifo_head_q),
		.rdata(ff_rd));

	// decode of the offered command
	logic          acc;
	logic [SW-1:0] in_slot;
	logic          bad_task, sub_ok, sch_ok, can_ok;
	logic [QW:0]   tail_sum;
	logic [QW-1:0] tail;

	assign acc      = cmd_ch.valid && cmd_ch.ready;
	assign in_slot  = SW'(cmd_ch.timer_slot);
	assign bad_task = (cmd_ch.task_id == 32'd0);
	assign sub_ok   = !bad_task && accepting && (32'(fifo_cnt_q) < 32'(QUEUE_DEPTH));
	assign sch_ok   = !bad_task && accepting && (free_cnt_q != '0)
		&& (32'(heap_cnt_q) < 32'(TIMER_SLOTS));
	assign can_ok   = (cmd_ch.timer_generation != 16'd0)
		&& (32'(cmd_ch.timer_slot) < 32'(TIMER_SLOTS)) && live_q[in_slot];
	assign tail_sum = (QW+1)'(fifo_head_q) + (QW+1)'(fifo_cnt_q);
	assign tail     = (32'(tail_sum) >= 32'(QUEUE_DEPTH))
		? QW'(32'(tail_sum) - 32'(QUEUE_DEPTH)) : QW'(tail_sum);

	// sequencer helpers
	logic [SW-1:0] fidx, s_new, last, par;
	logic [SW:0]   lc, rc;
	logic [15:0]   g_old, g_new;
	logic          l_in, r_in, up_lt, dn_l_lt, r_lt_l;
	tmhd_pkg::key_t mk;
	logic [SW-1:0]  ms;
	logic [SW-1:0]  mpos;

	assign fidx   = SW'(free_cnt_q - CW'(1));
	assign s_new  = freev_q[fidx] ? fr_rd : SW'(TIMER_SLOTS - 1 - 32'(fidx));
	assign last   = SW'(heap_cnt_q - CW'(1));
	assign par    = SW'((hole_q - SW'(1)) >> 1);
	assign lc     = {hole_q, 1'b1};
	assign rc     = lc + (SW+1)'(1);
	assign l_in   = 32'(lc) < 32'(heap_cnt_q);
	assign r_in   = 32'(rc) < 32'(heap_cnt_q);
	assign g_old  = genv_q[s_q] ? gen_rd : 16'd0;
	assign g_new  = (g_old == 16'hFFFF) ? 16'd1 : g_old + 16'd1;
	assign up_lt  = tmhd_pkg::earlier(xk_q, hk_rd);
	assign dn_l_lt = tmhd_pkg::earlier(hk_rd, xk_q);
	assign r_lt_l = tmhd_pkg::earlier(hk_rd, lk_q);
	assign mk     = r_lt_l ? hk_rd : lk_q;
	assign ms     = r_lt_l ? hs_rd : ls_q;
	assign mpos   = r_lt_l ? SW'(rc) : SW'(lc);

	always_comb begin
		hk_we  = 1'b0; hs_we = 1'b0; hk_wa = '0; hk_wd = xk_q; hs_wd = xs_q; hk_ra = '0;
		pos_we = 1'b0; pos_wa = xs_q; pos_wd = hole_q; pos_ra = in_slot;
		tsk_we = 1'b0; tsk_wa = s_new; tsk_wd = task_q; tsk_ra = hs_rd;
		gen_we = 1'b0; gen_wa = s_q; gen_wd = g_new; gen_ra = in_slot;
		fr_we  = 1'b0; fr_wa = SW'(free_cnt_q); fr_wd = s_q; fr_ra = SW'(free_cnt_q - CW'(1));
		ff_we  = 1'b0; ff_wa = tail; ff_wd = cmd_ch.task_id;
		unique case (st_q)
			S_IDLE: begin
				if (acc && cmd_ch.cmd == tmhd_pkg::CMD_SUBMIT && sub_ok) begin
					ff_we = 1'b1;
				end
			end
			S_SCHA: begin
				gen_ra = s_new;
				tsk_we = 1'b1;
			end
			S_SCHB: begin
				gen_we = 1'b1;
			end
			S_TK0: begin
				hk_ra = tp_q;
			end
			S_TK1: begin
				hk_ra = last;
			end
			S_TK2: begin
				fr_we = 1'b1;
				hk_ra = SW'((tp_q - SW'(1)) >> 1);
			end
			S_UP: begin
				hk_ra = par;
				if (hole_q == '0) begin
					hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; pos_we = 1'b1;
				end
			end
			S_UPB: begin
				if (up_lt) begin
					hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; hk_wd = hk_rd; hs_wd = hs_rd;
					pos_we = 1'b1; pos_wa = hs_rd;
				end else if (!first_q) begin
					hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; pos_we = 1'b1;
				end
			end
			S_DN: begin
				hk_ra = SW'(lc);
				if (!l_in) begin
					hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; pos_we = 1'b1;
				end
			end
			S_DNB: begin
				hk_ra = SW'(rc);
				if (!r_in) begin
					hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; pos_we = 1'b1;
					if (dn_l_lt) begin
						hk_wd = hk_rd; hs_wd = hs_rd; pos_wa = hs_rd;
					end
				end
			end
			S_DNC: begin
				hk_we = 1'b1; hs_we = 1'b1; hk_wa = hole_q; pos_we = 1'b1;
				if (tmhd_pkg::earlier(mk, xk_q)) begin
					hk_wd = mk; hs_wd = ms; pos_wa = ms;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			heap_cnt_q  <= '0;
			free_cnt_q  <= CW'(TIMER_SLOTS);
			fifo_head_q <= '0;
			fifo_cnt_q  <= '0;
			stamp_q     <= '0;
			live_q      <= '0;
			genv_q      <= '0;
			freev_q     <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			if (res_ch.ready) begin
				ovalid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q      <= cmd_ch.cmd;
						task_q     <= cmd_ch.task_id;
						dl_q       <= cmd_ch.deadline;
						tgen_q     <= cmd_ch.timer_generation;
						now_q      <= cmd_ch.now_tick;
						r_task_q   <= '0;
						r_slot_q   <= '0;
						r_gen_q    <= '0;
						r_ft_q     <= 1'b0;
						r_fl_q     <= '0;
						r_status_q <= tmhd_pkg::RS_ACCEPTED;
						fl_n_q     <= '0;
						tp_q       <= '0;
						st_q       <= S_DONE;
						case (cmd_ch.cmd)
							tmhd_pkg::CMD_SUBMIT, tmhd_pkg::CMD_SCHEDULE: begin
								if (bad_task) begin
									r_status_q <= tmhd_pkg::RS_INVALID;
								end else if (!accepting) begin
									r_status_q <= tmhd_pkg::RS_STOPPED;
								end else if (cmd_ch.cmd == tmhd_pkg::CMD_SUBMIT) begin
									if (sub_ok) begin
										fifo_cnt_q <= fifo_cnt_q + QCW'(1);
									end else begin
										r_status_q <= tmhd_pkg::RS_FULL;
									end
								end else if (sch_ok) begin
									st_q <= S_SCHA;
								end else begin
									r_status_q <= tmhd_pkg::RS_FULL;
								end
							end
							tmhd_pkg::CMD_CANCEL: begin
								s_q <= in_slot;
								if (can_ok) begin
									st_q <= S_CANA;
								end else begin
									r_status_q <= tmhd_pkg::RS_NOTFOUND;
								end
							end
							tmhd_pkg::CMD_DISPATCH: begin
								st_q <= S_DSPA;
							end
							tmhd_pkg::CMD_FLUSH: begin
								if (heap_cnt_q != '0) begin
									st_q <= S_TK0;
								end
							end
							default: begin
								r_status_q <= tmhd_pkg::RS_INVALID;
							end
						endcase
					end
				end
				S_SCHA: begin
					s_q        <= s_new;
					xs_q       <= s_new;
					xk_q       <= '{deadline: dl_q, stamp: stamp_q};
					stamp_q    <= (stamp_q == 32'hFFFF_FFFF) ? 32'd1 : stamp_q + 32'd1;
					free_cnt_q <= free_cnt_q - CW'(1);
					hole_q     <= SW'(heap_cnt_q);
					heap_cnt_q <= heap_cnt_q + CW'(1);
					live_q[s_new] <= 1'b1;
					first_q    <= 1'b0;
					st_q       <= S_SCHB;
				end
				S_SCHB: begin
					genv_q[s_q] <= 1'b1;
					r_slot_q    <= 4'(s_q);
					r_gen_q     <= g_new;
					st_q        <= S_UP;
				end
				S_CANA: begin
					if (gen_rd == tgen_q) begin
						tp_q <= pos_rd;
						st_q <= S_TK0;
					end else begin
						r_status_q <= tmhd_pkg::RS_NOTFOUND;
						st_q       <= S_DONE;
					end
				end
				S_DSPA: begin
					if (heap_cnt_q != '0 && hk_rd.deadline <= now_q) begin
						r_ft_q <= 1'b1;
						st_q   <= S_TK0;
					end else if (fifo_cnt_q != '0) begin
						r_task_q    <= ff_rd;
						fifo_head_q <= (32'(fifo_head_q) == QUEUE_DEPTH - 1) ? '0
							: fifo_head_q + QW'(1);
						fifo_cnt_q  <= fifo_cnt_q - QCW'(1);
						st_q        <= S_DONE;
					end else begin
						r_status_q <= tmhd_pkg::RS_NOTHING;
						st_q       <= S_DONE;
					end
				end
				S_TK0: begin
					st_q <= S_TK1;
				end
				S_TK1: begin
					s_q  <= hs_rd;
					st_q <= S_TK2;
				end
				S_TK2: begin
					xk_q          <= hk_rd;
					xs_q          <= hs_rd;
					heap_cnt_q    <= heap_cnt_q - CW'(1);
					free_cnt_q    <= free_cnt_q + CW'(1);
					freev_q[SW'(free_cnt_q)] <= 1'b1;
					live_q[s_q]   <= 1'b0;
					hole_q        <= tp_q;
					first_q       <= 1'b1;
					if (cmd_q == tmhd_pkg::CMD_DISPATCH) begin
						r_task_q <= tsk_rd;
					end
					if (tp_q == last) begin
						st_q <= S_END;
					end else if (tp_q != '0) begin
						st_q <= S_UPB;
					end else begin
						st_q <= S_DN;
					end
				end
				S_UP: begin
					st_q <= (hole_q == '0) ? S_END : S_UPB;
				end
				S_UPB: begin
					first_q <= 1'b0;
					if (up_lt) begin
						hole_q <= par;
						st_q   <= S_UP;
					end else begin
						st_q <= first_q ? S_DN : S_END;
					end
				end
				S_DN: begin
					st_q <= l_in ? S_DNB : S_END;
				end
				S_DNB: begin
					lk_q <= hk_rd;
					ls_q <= hs_rd;
					if (r_in) begin
						st_q <= S_DNC;
					end else if (dn_l_lt) begin
						hole_q <= SW'(lc);
						st_q   <= S_DN;
					end else begin
						st_q <= S_END;
					end
				end
				S_DNC: begin
					if (tmhd_pkg::earlier(mk, xk_q)) begin
						hole_q <= mpos;
						st_q   <= S_DN;
					end else begin
						st_q <= S_END;
					end
				end
				S_END: begin
					if (cmd_q == tmhd_pkg::CMD_FLUSH) begin
						fl_n_q <= fl_n_q + CW'(1);
						r_fl_q <= 5'(fl_n_q + CW'(1));
						tp_q   <= '0;
						st_q   <= (heap_cnt_q != '0) ? S_TK0 : S_DONE;
					end else begin
						st_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!ovalid_q || res_ch.ready) begin
						ovalid_q <= 1'b1;
						st_q     <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_DONE && (!ovalid_q || res_ch.ready)) begin
			o_status_q <= r_status_q;
			o_task_q   <= r_task_q;
			o_slot_q   <= r_slot_q;
			o_gen_q    <= r_gen_q;
			o_ft_q     <= r_ft_q;
			o_fl_q     <= r_fl_q;
		end
	end

	assign cmd_ch.ready          = (st_q == S_IDLE);
	assign res_ch.valid          = ovalid_q;
	assign res_ch.status         = o_status_q;
	assign res_ch.task_out       = o_task_q;
	assign res_ch.slot_out       = o_slot_q;
	assign res_ch.generation_out = o_gen_q;
	assign res_ch.from_timer     = o_ft_q;
	assign res_ch.flushed_count  = o_fl_q;

	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(heap_cnt_q) <= TIMER_SLOTS)
		else $error("heap count beyond slot count");
	a_slot_sum: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> 32'(heap_cnt_q) + 32'(free_cnt_q) == TIMER_SLOTS)
		else $error("heap and free counts disagree");
	a_live_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_IDLE |-> $countones(live_q) == 32'(heap_cnt_q))
		else $error("live slots disagree with heap count");
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fifo_cnt_q) <= QUEUE_DEPTH)
		else $error("ring count overflow");

endmodule
